### rtl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

  // item kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // write decode
  localparam logic [15:0] ADDR_LOW_LIMIT = 16'h4000;
  localparam logic [15:0] REG_MASK       = 16'h71FF;
  localparam logic [15:0] IRQ_MASK       = 16'hF1FF;
  localparam logic [15:0] ADDR_GAME      = 16'h4022;
  localparam logic [15:0] ADDR_LAYOUT    = 16'h4120;
  localparam logic [15:0] ADDR_IRQ       = 16'h4122;

  localparam logic [7:0] DIP_GAME_MODE  = 8'h00;
  localparam logic [7:0] DIP_HORIZONTAL = 8'h18;
  localparam logic [7:0] FIXED_FILL     = 8'h07;

  // 8K bank at 0xC000 in game table mode, indexed [layout_mode][game_bank_select]
  localparam logic [3:0] GAME_TABLE [0:1][0:7] = '{
    '{4'd4, 4'd3, 4'd5, 4'd3, 4'd6, 4'd3, 4'd7, 4'd3},
    '{4'd1, 4'd1, 4'd5, 4'd1, 4'd4, 4'd1, 4'd5, 4'd1}
  };

  typedef struct packed {
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0] outer_select;
    logic [2:0] game_bank_select;
    logic       layout_mode;
    logic       irq_enabled;
    logic       irq_pending;
  } mapper_state_t;

  typedef struct packed {
    logic [8:0] bank_8000;
    logic [8:0] bank_a000;
    logic [8:0] bank_c000;
    logic [8:0] bank_e000;
    logic       window_rom_mapped;
    logic [2:0] window_bank;
    logic       mirror_horizontal;
    logic       irq_line;
  } result_t;

  function automatic result_t map_banks(logic [7:0] dip, mapper_state_t st);
    result_t    r;
    logic [7:0] lo;
    logic [7:0] hi;
    lo = dip | {5'd0, st.outer_select};
    hi = dip | FIXED_FILL;
    if (dip == DIP_GAME_MODE) begin
      r.bank_8000         = {8'd0, !st.layout_mode};
      r.bank_a000         = 9'd0;
      r.bank_c000         = {5'd0, GAME_TABLE[st.layout_mode][st.game_bank_select]};
      r.bank_e000         = st.layout_mode ? 9'd8 : 9'd10;
      r.window_rom_mapped = 1'b1;
      r.window_bank       = st.layout_mode ? 3'd0 : 3'd2;
    end else begin
      r.bank_8000         = {lo, 1'b0};
      r.bank_a000         = {lo, 1'b1};
      r.bank_c000         = {hi, 1'b0};
      r.bank_e000         = {hi, 1'b1};
      r.window_rom_mapped = 1'b0;
      r.window_bank       = 3'd0;
    end
    r.mirror_horizontal = (dip == DIP_HORIZONTAL);
    r.irq_line          = st.irq_pending;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/cbm_cmd_if.sv
`default_nettype none

interface cbm_cmd_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, req_type, address, write_data, input ready);
  modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

`default_nettype wire

### rtl/cbm_res_if.sv
`default_nettype none

interface cbm_res_if;
  logic       valid;
  logic       ready;
  logic [8:0] bank_8000;
  logic [8:0] bank_a000;
  logic [8:0] bank_c000;
  logic [8:0] bank_e000;
  logic       window_rom_mapped;
  logic [2:0] window_bank;
  logic       mirror_horizontal;
  logic       irq_line;

  modport source (output valid, bank_8000, bank_a000, bank_c000, bank_e000,
                  window_rom_mapped, window_bank, mirror_horizontal, irq_line,
                  input ready);
  modport sink   (input valid, bank_8000, bank_a000, bank_c000, bank_e000,
                  window_rom_mapped, window_bank, mirror_horizontal, irq_line,
                  output ready);
endinterface

`default_nettype wire

### rtl/cbm_regs.sv
`default_nettype none

module cbm_regs #(
  parameter int IRQ_PERIOD = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  apply,
  input  wire cbm_pkg::cmd_word_t    word,
  output cbm_pkg::mapper_state_t     cur,
  output cbm_pkg::mapper_state_t     nxt
);
  import cbm_pkg::*;

  localparam int CW = (IRQ_PERIOD > 2) ? $clog2(IRQ_PERIOD) : 1;
  localparam logic [CW-1:0] COUNT_LAST = CW'(IRQ_PERIOD - 1);

  logic [CW-1:0] cycle_count;
  logic [CW-1:0] cycle_count_next;

  always_comb begin
    nxt              = cur;
    cycle_count_next = cycle_count;
    if (apply) begin
      if (word.req_type == REQ_TICK) begin
        if (cur.irq_enabled) begin
          if (cycle_count == COUNT_LAST) begin
            cycle_count_next = '0;
            nxt.irq_pending  = 1'b1;
          end else begin
            cycle_count_next = cycle_count + 1'b1;
          end
        end
      end else if (word.address >= ADDR_LOW_LIMIT) begin
        // several targets can decode from one write
        if (word.address[15]) begin
          nxt.outer_select = word.write_data[2:0];
        end
        if ((word.address & REG_MASK) == ADDR_GAME) begin
          nxt.game_bank_select = word.write_data[2:0];
        end
        if ((word.address & REG_MASK) == ADDR_LAYOUT) begin
          nxt.layout_mode = word.write_data[0];
        end
        if ((word.address & IRQ_MASK) == ADDR_IRQ) begin
          nxt.irq_enabled  = word.write_data[0];
          nxt.irq_pending  = 1'b0;
          cycle_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur         <= '0;
      cycle_count <= '0;
    end else begin
      cur         <= nxt;
      cycle_count <= cycle_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/cartridge_bank_mapper_with_cycle_irq.sv
// Cartridge bank mapper with a CPU-cycle IRQ counter.
//
// cmd (sink): one word per CPU event. req_type 0 is a CPU write (address,
//   write_data); req_type 1 is one CPU cycle tick.
// res (source): one word per cmd word, in order: four 8K program banks, the
//   0x6000 window mapping, mirroring and the IRQ line, all as they stand
//   after that cmd word has been applied.
// cfg_we/cfg_wdata: DIP switch setting; write only while no word is in flight.
//
// A cmd word accepted into the input register passes on through decode/update
// plus bank mapping into the result register, from which res shows it.
// Throughput: one word per clock while res is not held off; the mapper
// registers and IRQ counter update per word; consecutive words never wait.
// Stall: while res is held off, the result register keeps its word and the
// input register still takes one more; cmd.ready drops only when both full.
// Reset (rst, synchronous): all bank registers, the counter, the pending IRQ
// and the DIP setting go to zero; both pipeline stages empty.
`default_nettype none

module cartridge_bank_mapper_with_cycle_irq #(
  parameter int IRQ_PERIOD = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic [7:0] cfg_wdata,
  cbm_cmd_if.sink    cmd,
  cbm_res_if.source  res
);
  import cbm_pkg::*;

  // DIP switch register
  logic [7:0] dip;

  // input stage
  logic      s1_valid;
  cmd_word_t s1_word;
  logic      s1_move;

  // result stage
  logic    res_valid;
  result_t res_q;

  mapper_state_t st_cur;
  mapper_state_t st_nxt;

  // input stage drains into the result stage when that is empty or being taken
  assign s1_move   = s1_valid && (!res_valid || res.ready);
  assign cmd.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      dip <= '0;
    end else if (cfg_we) begin
      dip <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_word.req_type   <= cmd.req_type;
      s1_word.address    <= cmd.address;
      s1_word.write_data <= cmd.write_data;
    end
  end

  // mapper registers and IRQ counter; st_nxt is the state after s1_word
  cbm_regs #(
    .IRQ_PERIOD (IRQ_PERIOD)
  ) u_regs (
    .clk   (clk),
    .rst   (rst),
    .apply (s1_move),
    .word  (s1_word),
    .cur   (st_cur),
    .nxt   (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_q <= map_banks(dip, st_nxt);
    end
  end

  assign res.valid             = res_valid;
  assign res.bank_8000         = res_q.bank_8000;
  assign res.bank_a000         = res_q.bank_a000;
  assign res.bank_c000         = res_q.bank_c000;
  assign res.bank_e000         = res_q.bank_e000;
  assign res.window_rom_mapped = res_q.window_rom_mapped;
  assign res.window_bank       = res_q.window_bank;
  assign res.mirror_horizontal = res_q.mirror_horizontal;
  assign res.irq_line          = res_q.irq_line;

  // back-pressure only when both stages hold a word and res is stalled
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (s1_valid && res_valid && !res.ready))
    else $error("cmd.ready low with room in the pipeline");

  // the IRQ is raised only by a tick passing through the update stage
  a_irq_source: assert property (@(posedge clk) disable iff (rst)
    $rose(st_cur.irq_pending) |-> $past(s1_move && s1_word.req_type == REQ_TICK))
    else $error("irq pending raised without a tick");

  // switch mode: window unmapped and 0xA000 is the upper half of the 0x8000 pair
  a_switch_pair: assert property (@(posedge clk) disable iff (rst)
    (res_valid && dip != DIP_GAME_MODE) |->
      (!res.window_rom_mapped && res.bank_a000 == (res.bank_8000 | 9'd1)))
    else $error("switch mode bank pair mismatch");

endmodule

`default_nettype wire

### tb/cartridge_bank_mapper_with_cycle_irq_tb.sv
`timescale 1ns / 100ps

module cartridge_bank_mapper_with_cycle_irq_tb;
  import cbm_pkg::*;

  localparam int IRQ_PERIOD = 4096;
  // Leave lots of headroom over the slowest honest run.
  localparam int CYCLE_LIMIT = 600000;
  // Least number of random words per segment (8 segments, 896 or more in all).
  localparam int WORDS_PER_SEG = 112;
  localparam int NUM_SEGS = 8;

  // 8K bank at 0xC000 in game table mode, [layout][game select]
  localparam logic [8:0] C000_BANKS [2][8] = '{
    '{9'd4, 9'd3, 9'd5, 9'd3, 9'd6, 9'd3, 9'd7, 9'd3},
    '{9'd1, 9'd1, 9'd5, 9'd1, 9'd4, 9'd1, 9'd5, 9'd1}
  };

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  cbm_cmd_if cmd_bus ();
  cbm_res_if res_bus ();

  cartridge_bank_mapper_with_cycle_irq #(
    .IRQ_PERIOD(IRQ_PERIOD)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd_bus),
    .res      (res_bus)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mapper shadow: registers as the block should hold them, updated per
  // accepted cmd word. The DIP value is only changed while nothing is in flight.
  // ---------------------------------------------------------------------------
  logic [7:0] dip_now = 8'd0;
  logic [2:0] sel_outer = 3'd0;
  logic [2:0] sel_game = 3'd0;
  logic       layout_q = 1'b0;
  logic       irq_on = 1'b0;
  int         tick_count = 0;
  logic       irq_flag = 1'b0;

  cmd_word_t  cmd_q [$];      // words waiting for the driver
  result_t    mapping_q [$];  // mappings expected on res, oldest first
  int         words_total = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         elapsed_cycles = 0;
  logic       cmd_taken = 1'b0;
  idle_mode_t idle_mode = IDLE_NONE;
  result_t    oldest;
  cmd_word_t  nxt_word;

  // Decode one word into the shadow registers. Several targets may hit at once.
  function void update_mapper(cmd_word_t w);
    if (w.req_type == REQ_TICK) begin
      // counter only runs while the IRQ is enabled
      if (irq_on) begin
        tick_count++;
        if (tick_count >= IRQ_PERIOD) begin
          tick_count = 0;
          irq_flag = 1'b1;
        end
      end
    end else if (w.address >= ADDR_LOW_LIMIT) begin
      if (w.address[15])
        sel_outer = w.write_data[2:0];
      if ((w.address & REG_MASK) == ADDR_GAME)
        sel_game = w.write_data[2:0];
      if ((w.address & REG_MASK) == ADDR_LAYOUT)
        layout_q = w.write_data[0];
      // any enable write clears the counter and drops a pending IRQ
      if ((w.address & IRQ_MASK) == ADDR_IRQ) begin
        irq_on = w.write_data[0];
        tick_count = 0;
        irq_flag = 1'b0;
      end
    end
  endfunction

  // Bank view after the latest word.
  function result_t bank_map();
    result_t    r;
    logic [8:0] lo16;
    logic [8:0] hi16;
    lo16 = {1'b0, dip_now | {5'd0, sel_outer}};
    hi16 = {1'b0, dip_now | FIXED_FILL};
    if (dip_now == DIP_GAME_MODE) begin
      r.bank_8000 = layout_q ? 9'd0 : 9'd1;
      r.bank_a000 = 9'd0;
      r.bank_c000 = C000_BANKS[layout_q][sel_game];
      r.bank_e000 = layout_q ? 9'd8 : 9'd10;
      r.window_rom_mapped = 1'b1;
      r.window_bank = layout_q ? 3'd0 : 3'd2;
    end else begin
      // 16K banks handed out as 8K pairs
      r.bank_8000 = 9'(lo16 * 2);
      r.bank_a000 = 9'(lo16 * 2 + 1);
      r.bank_c000 = 9'(hi16 * 2);
      r.bank_e000 = 9'(hi16 * 2 + 1);
      r.window_rom_mapped = 1'b0;
      r.window_bank = 3'd0;
    end
    r.mirror_horizontal = (dip_now == DIP_HORIZONTAL);
    r.irq_line = irq_flag;
    return r;
  endfunction

  task automatic check_field(input string fld, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fld, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Flow control per segment: 63% gaps on one side, 7% on both, or none.
  // ---------------------------------------------------------------------------
  function bit sender_rests();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 63;
      IDLE_BOTH:   return $urandom_range(0, 99) < 7;
      default:     return 1'b0;
    endcase
  endfunction

  function bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 63;
      IDLE_BOTH:     return $urandom_range(0, 99) < 7;
      default:       return 1'b0;
    endcase
  endfunction

  // Driver: new word goes out on the falling edge once the last one was taken.
  always @(negedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || cmd_taken) begin
      if (cmd_q.size() > 0 && !sender_rests()) begin
        nxt_word = cmd_q.pop_front();
        cmd_bus.valid      <= 1'b1;
        cmd_bus.req_type   <= nxt_word.req_type;
        cmd_bus.address    <= nxt_word.address;
        cmd_bus.write_data <= nxt_word.write_data;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst)
      res_bus.ready <= 1'b0;
    else
      res_bus.ready <= !receiver_stalls();
  end

  // Accepted cmd word: advance the shadow and queue the mapping it should give.
  always @(posedge clk) begin
    cmd_taken <= !rst && cmd_bus.valid && cmd_bus.ready;
    if (!rst && cmd_bus.valid && cmd_bus.ready) begin
      update_mapper('{req_type: cmd_bus.req_type, address: cmd_bus.address,
                      write_data: cmd_bus.write_data});
      mapping_q.push_back(bank_map());
    end
  end

  // Monitor: every res word is held against the oldest expected mapping.
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (mapping_q.size() == 0) begin
        $error("res word with no mapping expected");
        mismatches++;
      end else begin
        oldest = mapping_q.pop_front();
        results_seen++;
        check_field("bank_8000", oldest.bank_8000, res_bus.bank_8000);
        check_field("bank_a000", oldest.bank_a000, res_bus.bank_a000);
        check_field("bank_c000", oldest.bank_c000, res_bus.bank_c000);
        check_field("bank_e000", oldest.bank_e000, res_bus.bank_e000);
        check_field("window_rom_mapped", oldest.window_rom_mapped,
                    res_bus.window_rom_mapped);
        check_field("window_bank", oldest.window_bank, res_bus.window_bank);
        check_field("mirror_horizontal", oldest.mirror_horizontal,
                    res_bus.mirror_horizontal);
        check_field("irq_line", oldest.irq_line, res_bus.irq_line);
      end
    end
  end

  always @(posedge clk) begin
    elapsed_cycles++;
    if (elapsed_cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_write(input logic [15:0] addr, input logic [7:0] data);
    cmd_q.push_back('{req_type: REQ_WRITE, address: addr, write_data: data});
    words_total++;
  endtask

  // ticks carry random payload; the block must ignore it
  task automatic push_ticks(input int n);
    repeat (n) begin
      cmd_q.push_back('{req_type: REQ_TICK, address: 16'($urandom),
                        write_data: 8'($urandom)});
      words_total++;
    end
  endtask

  // register address with the don't-care bits of its decode filled at random
  function automatic logic [15:0] reg_addr(logic [15:0] base, logic [15:0] mask);
    return base | (16'($urandom) & ~mask);
  endfunction

  function automatic logic [15:0] low_addr();
    return 16'($urandom_range(0, ADDR_LOW_LIMIT - 1));
  endfunction

  task automatic random_segment();
    int seg_start;
    seg_start = words_total;
    while (words_total - seg_start < WORDS_PER_SEG) begin
      case ($urandom_range(0, 9))
        0: push_write(reg_addr(ADDR_GAME, REG_MASK), 8'($urandom));
        1: push_write(reg_addr(ADDR_LAYOUT, REG_MASK), 8'($urandom));
        2: push_write(reg_addr(ADDR_IRQ, IRQ_MASK), 8'($urandom));
        3: push_write({1'b1, 15'($urandom)}, 8'($urandom));
        4: push_write(low_addr(), 8'($urandom));
        5: push_write(16'($urandom), 8'($urandom));
        6, 7: push_ticks($urandom_range(1, 24));
        default: begin
          push_write(reg_addr(ADDR_IRQ, IRQ_MASK), 8'($urandom) | 8'h01);
          push_ticks($urandom_range(1, 40));
        end
      endcase
    end
  endtask

  // Wait for every queued word to come back.
  task automatic drain();
    while (results_seen < words_total)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_dip(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    dip_now = v;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] dip_plan [NUM_SEGS];
    cmd_bus.valid = 1'b0;
    cmd_bus.req_type = REQ_WRITE;
    cmd_bus.address = 16'd0;
    cmd_bus.write_data = 8'd0;
    res_bus.ready = 1'b0;

    // game mode, both switch extremes, the horizontal-mirror value, odd ones
    dip_plan = '{8'h00, 8'hFF, DIP_HORIZONTAL, 8'h01, 8'($urandom_range(1, 255)),
                 8'h00, 8'h80, 8'($urandom_range(0, 255))};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain();
      set_dip(dip_plan[seg]);
      idle_mode = idle_mode_t'(seg % 4);
      if (seg == 0) begin
        // directed opener in game table mode
        push_write(16'h0000, 8'hFF);                 // low writes: ignored
        push_write(ADDR_LOW_LIMIT - 16'd1, 8'hFF);
        push_ticks(1);                               // counter off: no effect
        push_write(ADDR_GAME, 8'hFF);
        push_write(ADDR_LAYOUT, 8'hFF);
        push_write(ADDR_GAME, 8'h02);
        push_write(ADDR_LAYOUT, 8'hFE);
        push_write(16'hFFFF, 8'hFF);                 // outer only
        push_write(16'h8000, 8'h00);
        push_write(ADDR_GAME | 16'h8000, 8'h05);     // outer and game together
        push_write(ADDR_IRQ, 8'h01);
        push_ticks(3);
        push_write(ADDR_IRQ | 16'h0E00, 8'hFE);      // don't-care bits set: disable
        push_ticks(1);
        push_write(ADDR_IRQ | 16'h8000, 8'h01);      // bit 15 kills IRQ decode
        push_write(ADDR_LOW_LIMIT, 8'hAA);           // lowest decoded, no target
      end
      random_segment();
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && mapping_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
